@@ rtl/core/gjd_pkg.sv @@
// Shared types, op codes and calendar tables of the Gregorian date unit.
// No dependencies; used by gjd_fwd, gjd_rev and the top level.
package gjd_pkg;

  // Register stages from input word to output word
  localparam int GJD_STAGES = 10;

  localparam logic [1:0] OP_TO_JDN     = 2'd0;
  localparam logic [1:0] OP_TO_YMD     = 2'd1;
  localparam logic [1:0] OP_ADD_MONTHS = 2'd2;
  localparam logic [1:0] OP_ADD_YEARS  = 2'd3;

  // 0000-01-01 and 9999-12-31
  localparam logic [22:0] JDN_MIN = 23'd1721060;
  localparam logic [22:0] JDN_MAX = 23'd5373484;

  // One load enable per pipeline stage
  typedef logic [GJD_STAGES-1:0] gjd_adv_t;

  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [22:0] jdn;
    logic        bad;
  } gjd_result_t;

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
      4'd2:                                        len = leap ? 5'd29 : 5'd28;
      default:                                     len = 5'd0;
    endcase
    return len;
  endfunction

  // 367 * (m - 2 + 12*[m <= 2]) / 12
  function automatic logic [8:0] month_offset(input logic [3:0] m);
    logic [8:0] v;
    unique case (m)
      4'd1:    v = 9'd336;
      4'd2:    v = 9'd367;
      4'd3:    v = 9'd30;
      4'd4:    v = 9'd61;
      4'd5:    v = 9'd91;
      4'd6:    v = 9'd122;
      4'd7:    v = 9'd152;
      4'd8:    v = 9'd183;
      4'd9:    v = 9'd214;
      4'd10:   v = 9'd244;
      4'd11:   v = 9'd275;
      4'd12:   v = 9'd305;
      default: v = 9'd0;
    endcase
    return v;
  endfunction

  // (153 * mm + 2) / 5, mm counts months from March
  function automatic logic [8:0] day_base(input logic [3:0] mm);
    logic [8:0] v;
    unique case (mm)
      4'd0:    v = 9'd0;
      4'd1:    v = 9'd31;
      4'd2:    v = 9'd61;
      4'd3:    v = 9'd92;
      4'd4:    v = 9'd122;
      4'd5:    v = 9'd153;
      4'd6:    v = 9'd184;
      4'd7:    v = 9'd214;
      4'd8:    v = 9'd245;
      4'd9:    v = 9'd275;
      4'd10:   v = 9'd306;
      4'd11:   v = 9'd337;
      default: v = 9'd0;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/core/gjd_fwd.sv @@
// Date check, month/year shift and date to Julian day number, 7 stages plus delay.
// Depends on gjd_pkg; stage enables come from the top level.
module gjd_fwd (
  input  logic                clk,
  input  gjd_pkg::gjd_adv_t   ld,
  input  logic [1:0]          operation,
  input  logic [13:0]         year_in,
  input  logic [3:0]          month_in,
  input  logic [4:0]          day_in,
  input  logic signed [17:0]  delta,
  output gjd_pkg::gjd_result_t res
);

  localparam int FWD_DEPTH = 7;
  localparam int DLY       = gjd_pkg::GJD_STAGES - FWD_DEPTH;

  // stage 0: y/100 estimate, month index, shifted year
  logic [26:0]        y_prod0;
  logic [17:0]        ym12;
  logic signed [19:0] t_n;
  logic signed [19:0] ys_n;
  logic [1:0]         s0_op;
  logic [13:0]        s0_y;
  logic [3:0]         s0_m;
  logic [4:0]         s0_d;
  logic [7:0]         s0_q100;
  logic signed [19:0] s0_t;
  logic signed [19:0] s0_ys;

  assign y_prod0 = {13'd0, year_in} * 27'd5243;
  assign ym12    = {1'b0, year_in, 3'b0} + {2'b0, year_in, 2'b0};
  assign t_n     = {2'b0, ym12} + {16'd0, month_in} + {{2{delta[17]}}, delta} - 20'd1;
  assign ys_n    = {6'd0, year_in} + {{2{delta[17]}}, delta};

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      s0_op   <= operation;
      s0_y    <= year_in;
      s0_m    <= month_in;
      s0_d    <= day_in;
      s0_q100 <= y_prod0[26:19];
      s0_t    <= t_n;
      s0_ys   <= ys_n;
    end
  end

  // stage 1: input validity, range checks, t/12 estimate
  logic [14:0] c100_1;
  logic        leap1;
  logic        date_ok;
  logic        t_ok;
  logic        ys_ok;
  logic [33:0] t_prod;
  logic        bad1;
  logic [1:0]  s1_op;
  logic [13:0] s1_y;
  logic [3:0]  s1_m;
  logic [4:0]  s1_d;
  logic [13:0] s1_tq;
  logic [16:0] s1_t;
  logic [13:0] s1_ys;
  logic        s1_bad;

  assign c100_1  = {7'd0, s0_q100} * 15'd100;
  assign leap1   = (s0_y[1:0] == 2'd0) && (({1'b0, s0_y} != c100_1) || (s0_q100[1:0] == 2'd0));
  assign date_ok = (s0_y <= 14'd9999) && (s0_d != 5'd0) &&
                   (s0_d <= gjd_pkg::month_len(s0_m, leap1));
  assign t_ok    = !s0_t[19] && (s0_t[18:0] <= 19'd119999);
  assign ys_ok   = !s0_ys[19] && (s0_ys[18:0] <= 19'd9999);
  assign t_prod  = {17'd0, s0_t[16:0]} * 34'd87382;
  assign bad1    = !date_ok ||
                   ((s0_op == gjd_pkg::OP_ADD_MONTHS) && !t_ok) ||
                   ((s0_op == gjd_pkg::OP_ADD_YEARS) && !ys_ok);

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      s1_op  <= s0_op;
      s1_y   <= s0_y;
      s1_m   <= s0_m;
      s1_d   <= s0_d;
      s1_tq  <= t_prod[33:20];
      s1_t   <= s0_t[16:0];
      s1_ys  <= s0_ys[13:0];
      s1_bad <= bad1;
    end
  end

  // stage 2: pick the new year and month
  logic [16:0] tq12;
  logic [16:0] mrem;
  logic [13:0] ny2;
  logic [3:0]  nm2;
  logic [13:0] s2_y;
  logic [3:0]  s2_m;
  logic [4:0]  s2_d;
  logic        s2_bad;

  assign tq12 = {s1_tq, 3'b0} + {1'b0, s1_tq, 2'b0};
  assign mrem = s1_t - tq12;

  always_comb begin
    unique case (s1_op)
      gjd_pkg::OP_ADD_MONTHS: begin
        ny2 = s1_tq;
        nm2 = mrem[3:0] + 4'd1;
      end
      gjd_pkg::OP_ADD_YEARS: begin
        ny2 = s1_ys;
        nm2 = s1_m;
      end
      default: begin
        ny2 = s1_y;
        nm2 = s1_m;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      s2_y   <= ny2;
      s2_m   <= nm2;
      s2_d   <= s1_d;
      s2_bad <= s1_bad;
    end
  end

  // stage 3: new year / 100
  logic [26:0] y_prod3;
  logic [7:0]  s3_q100;
  logic [13:0] s3_y;
  logic [3:0]  s3_m;
  logic [4:0]  s3_d;
  logic        s3_bad;

  assign y_prod3 = {13'd0, s2_y} * 27'd5243;

  always_ff @(posedge clk) begin
    if (ld[3]) begin
      s3_q100 <= y_prod3[26:19];
      s3_y    <= s2_y;
      s3_m    <= s2_m;
      s3_d    <= s2_d;
      s3_bad  <= s2_bad;
    end
  end

  // stage 4: clamp day to the new month length
  logic [14:0] c100_4;
  logic        leap4;
  logic [4:0]  len4;
  logic [13:0] s4_y;
  logic [3:0]  s4_m;
  logic [4:0]  s4_d;
  logic        s4_bad;

  assign c100_4 = {7'd0, s3_q100} * 15'd100;
  assign leap4  = (s3_y[1:0] == 2'd0) && (({1'b0, s3_y} != c100_4) || (s3_q100[1:0] == 2'd0));
  assign len4   = gjd_pkg::month_len(s3_m, leap4);

  always_ff @(posedge clk) begin
    if (ld[4]) begin
      s4_y   <= s3_y;
      s4_m   <= s3_m;
      s4_d   <= (s3_d > len4) ? len4 : s3_d;
      s4_bad <= s3_bad;
    end
  end

  // stage 5: Fliegel-van Flandern products
  logic        jan_feb;
  logic [14:0] yy5;
  logic [14:0] cc5;
  logic [25:0] p_prod;
  logic [27:0] q_prod;
  logic [25:0] s5_p;
  logic [8:0]  s5_qc;
  logic [8:0]  s5_mo;
  logic [13:0] s5_y;
  logic [3:0]  s5_m;
  logic [4:0]  s5_d;
  logic        s5_bad;

  assign jan_feb = (s4_m <= 4'd2);
  assign yy5     = {1'b0, s4_y} + 15'd4800 - {14'd0, jan_feb};
  assign cc5     = {1'b0, s4_y} + 15'd4900 - {14'd0, jan_feb};
  assign p_prod  = {11'd0, yy5} * 26'd1461;
  assign q_prod  = {13'd0, cc5} * 28'd5243;

  always_ff @(posedge clk) begin
    if (ld[5]) begin
      s5_p   <= p_prod;
      s5_qc  <= q_prod[27:19];
      s5_mo  <= gjd_pkg::month_offset(s4_m);
      s5_y   <= s4_y;
      s5_m   <= s4_m;
      s5_d   <= s4_d;
      s5_bad <= s4_bad;
    end
  end

  // stage 6: final sum
  logic [10:0] qc3;
  logic [23:0] jsum;
  gjd_pkg::gjd_result_t s6_res;

  assign qc3  = {1'b0, s5_qc, 1'b0} + {2'b0, s5_qc};
  assign jsum = s5_p[25:2] + {19'd0, s5_d} + {15'd0, s5_mo} - 24'd32075 - {15'd0, qc3[10:2]};

  always_ff @(posedge clk) begin
    if (ld[6]) begin
      if (s5_bad) begin
        s6_res <= '{year: 14'd0, month: 4'd0, day: 5'd0, jdn: 23'd0, bad: 1'b1};
      end else begin
        s6_res <= '{year: s5_y, month: s5_m, day: s5_d, jdn: jsum[22:0], bad: 1'b0};
      end
    end
  end

  // delay to line up with the Julian-to-date path
  gjd_pkg::gjd_result_t dly [DLY];

  always_ff @(posedge clk) begin
    for (int k = 0; k < DLY; k++) begin
      if (ld[FWD_DEPTH + k]) begin
        dly[k] <= (k == 0) ? s6_res : dly[(k == 0) ? 0 : k - 1];
      end
    end
  end

  assign res = dly[DLY-1];

endmodule

@@ rtl/core/gjd_rev.sv @@
// Julian day number to Gregorian date (Calendar FAQ inverse), 10 stages.
// Depends on gjd_pkg; divisions by constants as reciprocal estimate plus correction.
module gjd_rev (
  input  logic                 clk,
  input  gjd_pkg::gjd_adv_t    ld,
  input  logic [22:0]          julian_in,
  output gjd_pkg::gjd_result_t res
);

  localparam int LAST = gjd_pkg::GJD_STAGES - 1;

  // day number and range flag ride alongside
  logic [22:0] j_q   [LAST];
  logic        bad_q [LAST];

  always_ff @(posedge clk) begin
    for (int k = 0; k < LAST; k++) begin
      if (ld[k]) begin
        if (k == 0) begin
          j_q[k]   <= julian_in;
          bad_q[k] <= (julian_in < gjd_pkg::JDN_MIN) || (julian_in > gjd_pkg::JDN_MAX);
        end else begin
          j_q[k]   <= j_q[(k == 0) ? 0 : k - 1];
          bad_q[k] <= bad_q[(k == 0) ? 0 : k - 1];
        end
      end
    end
  end

  // s0: x1 = 4*(j + 32045) - 1
  logic [24:0] s0_x1;

  always_ff @(posedge clk) begin
    if (ld[0]) s0_x1 <= {julian_in, 2'b0} + 25'd128179;
  end

  // s1: b estimate = x1 / 146097
  logic [32:0] q1_prod;
  logic [24:0] s1_x1;
  logic [7:0]  s1_q1;

  assign q1_prod = {8'd0, s0_x1} * 33'd229;

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      s1_x1 <= s0_x1;
      s1_q1 <= q1_prod[32:25];
    end
  end

  // s2: back-multiply
  logic [24:0] s2_x1;
  logic [7:0]  s2_q1;
  logic [25:0] s2_p1;

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      s2_x1 <= s1_x1;
      s2_q1 <= s1_q1;
      s2_p1 <= {18'd0, s1_q1} * 26'd146097;
    end
  end

  // s3: correct b, keep remainder
  logic [25:0] r0;
  logic [25:0] r0d;
  logic        ge1;
  logic [7:0]  s3_b;
  logic [17:0] s3_r1;

  assign r0  = {1'b0, s2_x1} - s2_p1;
  assign r0d = r0 - 26'd146097;
  assign ge1 = (r0 >= 26'd146097);

  always_ff @(posedge clk) begin
    if (ld[3]) begin
      s3_b  <= ge1 ? s2_q1 + 8'd1 : s2_q1;
      s3_r1 <= ge1 ? r0d[17:0] : r0[17:0];
    end
  end

  // s4: x2 = 4c - 1 = r + (b mod 4), e estimate = x2 / 1461
  logic [17:0] x2;
  logic [25:0] q2_prod;
  logic [17:0] s4_x2;
  logic [7:0]  s4_q2;
  logic [7:0]  s4_b;

  assign x2      = s3_r1 + {16'd0, s3_b[1:0]};
  assign q2_prod = {8'd0, x2} * 26'd179;

  always_ff @(posedge clk) begin
    if (ld[4]) begin
      s4_x2 <= x2;
      s4_q2 <= q2_prod[25:18];
      s4_b  <= s3_b;
    end
  end

  // s5: back-multiply
  logic [17:0] s5_x2;
  logic [7:0]  s5_q2;
  logic [18:0] s5_p2;
  logic [7:0]  s5_b;

  always_ff @(posedge clk) begin
    if (ld[5]) begin
      s5_x2 <= s4_x2;
      s5_q2 <= s4_q2;
      s5_p2 <= {11'd0, s4_q2} * 19'd1461;
      s5_b  <= s4_b;
    end
  end

  // s6: correct e
  logic [18:0] r20;
  logic [18:0] r20d;
  logic        ge2;
  logic [7:0]  s6_e;
  logic [10:0] s6_r2;
  logic [7:0]  s6_b;

  assign r20  = {1'b0, s5_x2} - s5_p2;
  assign r20d = r20 - 19'd1461;
  assign ge2  = (r20 >= 19'd1461);

  always_ff @(posedge clk) begin
    if (ld[6]) begin
      s6_e  <= ge2 ? s5_q2 + 8'd1 : s5_q2;
      s6_r2 <= ge2 ? r20d[10:0] : r20[10:0];
      s6_b  <= s5_b;
    end
  end

  // s7: day of year f, month estimate (5f - 3) / 153
  logic [11:0] fs;
  logic [8:0]  f7;
  logic [10:0] x3;
  logic [14:0] q3_prod;
  logic [8:0]  s7_f;
  logic [10:0] s7_x3;
  logic [3:0]  s7_q3;
  logic [7:0]  s7_e;
  logic [7:0]  s7_b;

  assign fs      = {1'b0, s6_r2} + 12'd1 + {10'd0, s6_e[1:0]};
  assign f7      = fs[10:2];
  assign x3      = {f7, 2'b0} + {2'b0, f7} - 11'd3;
  assign q3_prod = {4'd0, x3} * 15'd13;

  always_ff @(posedge clk) begin
    if (ld[7]) begin
      s7_f  <= f7;
      s7_x3 <= x3;
      s7_q3 <= q3_prod[14:11];
      s7_e  <= s6_e;
      s7_b  <= s6_b;
    end
  end

  // s8: correct month index
  logic [11:0] p3;
  logic [11:0] p3_hi;
  logic [3:0]  s8_mm;
  logic [8:0]  s8_f;
  logic [7:0]  s8_e;
  logic [7:0]  s8_b;

  assign p3    = {8'd0, s7_q3} * 12'd153;
  assign p3_hi = p3 + 12'd153;

  always_ff @(posedge clk) begin
    if (ld[8]) begin
      s8_mm <= ({1'b0, s7_x3} >= p3_hi) ? s7_q3 + 4'd1 : s7_q3;
      s8_f  <= s7_f;
      s8_e  <= s7_e;
      s8_b  <= s7_b;
    end
  end

  // s9: assemble the date
  logic        wrap;
  logic [8:0]  dd;
  logic [14:0] yy;
  logic [3:0]  mo;

  assign wrap = (s8_mm >= 4'd10);
  assign dd   = s8_f - gjd_pkg::day_base(s8_mm);
  assign mo   = wrap ? s8_mm - 4'd9 : s8_mm + 4'd3;
  assign yy   = {7'd0, s8_b} * 15'd100 + {7'd0, s8_e} + {14'd0, wrap} - 15'd4800;

  always_ff @(posedge clk) begin
    if (ld[LAST]) begin
      if (bad_q[LAST-1]) begin
        res <= '{year: 14'd0, month: 4'd0, day: 5'd0, jdn: 23'd0, bad: 1'b1};
      end else begin
        res <= '{year: yy[13:0], month: mo, day: dd[4:0], jdn: j_q[LAST-1], bad: 1'b0};
      end
    end
  end

endmodule

@@ rtl/core/gregorian_julian_day_date_unit_top.sv @@
// Top level of the Gregorian date unit: handshake, valid pipeline and result select.
// Depends on gjd_pkg, gjd_fwd and gjd_rev.
//
//   channel  handshake           payload
//   in       in_valid/in_stall   operation, year_in, month_in, day_in, julian_in, delta
//   out      out_valid/out_stall year_out, month_out, day_out, julian_out, bad_date
//
// Every word passes through gjd_pkg::GJD_STAGES (10) register stages; one word can
// enter per cycle, so the sustained rate is one word per clock while out_stall is low. The depth
// is set by the Julian-to-date chain of three reciprocal divisions with correction.
// Reset (rst, synchronous) clears only the stage valid bits; data registers keep junk.
// A stage loads when it is empty or the stage after it moves, so out_stall backs up
// through the valid bits to in_stall without dropping or repeating a word.
module gregorian_julian_day_date_unit_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         operation,
  input  logic [13:0]        year_in,
  input  logic [3:0]         month_in,
  input  logic [4:0]         day_in,
  input  logic [22:0]        julian_in,
  input  logic signed [17:0] delta,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [13:0]        year_out,
  output logic [3:0]         month_out,
  output logic [4:0]         day_out,
  output logic [22:0]        julian_out,
  output logic               bad_date
);

  localparam int LAST = gjd_pkg::GJD_STAGES - 1;

  logic [LAST:0]        vld;     // stage valid bits
  logic [LAST:0]        use_rev; // word is a Julian-to-date conversion
  gjd_pkg::gjd_adv_t    rdy;     // stage may load this cycle
  gjd_pkg::gjd_result_t fwd_res;
  gjd_pkg::gjd_result_t rev_res;
  gjd_pkg::gjd_result_t sel_res;

  // Ready ripples back from the output
  always_comb begin
    rdy[LAST] = !vld[LAST] || !out_stall;
    for (int k = LAST - 1; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign in_stall = !rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) vld[0] <= in_valid;
      for (int k = 1; k <= LAST; k++) begin
        if (rdy[k]) vld[k] <= vld[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) use_rev[0] <= (operation == gjd_pkg::OP_TO_YMD);
    for (int k = 1; k <= LAST; k++) begin
      if (rdy[k]) use_rev[k] <= use_rev[k-1];
    end
  end

  // Date check, shifts and date-to-Julian path (ops 0, 2, 3)
  gjd_fwd u_fwd (
    .clk       (clk),
    .ld        (rdy),
    .operation (operation),
    .year_in   (year_in),
    .month_in  (month_in),
    .day_in    (day_in),
    .delta     (delta),
    .res       (fwd_res)
  );

  // Julian-to-date path (op 1)
  gjd_rev u_rev (
    .clk       (clk),
    .ld        (rdy),
    .julian_in (julian_in),
    .res       (rev_res)
  );

  // Both paths end in registers, so the output word holds while stalled
  assign sel_res    = use_rev[LAST] ? rev_res : fwd_res;
  assign out_valid  = vld[LAST];
  assign year_out   = sel_res.year;
  assign month_out  = sel_res.month;
  assign day_out    = sel_res.day;
  assign julian_out = sel_res.jdn;
  assign bad_date   = sel_res.bad;

endmodule
